[rtl/core/io_expander_poll_controller_assert.svh]
// Assertion macros used by the I/O expander poll controller core.
`ifndef IO_EXPANDER_POLL_CONTROLLER_ASSERT_SVH
`define IO_EXPANDER_POLL_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define IEPC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define IEPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/iepc_pkg.sv]
// Types and constants of the I/O expander poll controller.
`default_nettype none

package iepc_pkg;

  localparam int KIND_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int PIN_W     = 4;
  localparam int ISSUE_W   = 2;
  localparam int PERIOD_W  = 10;
  localparam int ELAPSED_W = 11;

  localparam logic [BYTE_W-1:0]   BYTE_RESET   = 8'hFF;
  localparam logic [PIN_W-1:0]    PIN_MAX      = 4'd7;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_WRITE_BYTE = 3'd1,
    KIND_SET_PIN    = 3'd2,
    KIND_REQ_READ   = 3'd3,
    KIND_BUS_DONE   = 3'd4,
    KIND_GET_PIN    = 3'd5
  } kind_e;

  typedef enum logic [ISSUE_W-1:0] {
    ISSUE_NONE  = 2'd0,
    ISSUE_WRITE = 2'd1,
    ISSUE_READ  = 2'd2
  } issue_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [PIN_W-1:0]  pin;
    logic              pin_level;
    logic [BYTE_W-1:0] read_data;
  } iepc_item_t;

  typedef struct packed {
    logic       valid;
    iepc_item_t item;
  } iepc_stage_t;

  typedef struct packed {
    issue_e            issue;
    logic [BYTE_W-1:0] bus_data;
    logic              pin_value;
    logic [BYTE_W-1:0] input_byte;
  } iepc_result_t;

endpackage

`default_nettype wire

[rtl/core/iepc_if.sv]
// Valid/ready channel interfaces for command items and results.
`default_nettype none

interface iepc_in_if;
  import iepc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data;
  logic [PIN_W-1:0]  pin;
  logic              pin_level;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, output kind, output data, output pin, output pin_level,
                  output read_data, input ready);
  modport sink (input valid, input kind, input data, input pin, input pin_level,
                input read_data, output ready);
endinterface

interface iepc_out_if;
  import iepc_pkg::*;

  logic               valid;
  logic               ready;
  logic [ISSUE_W-1:0] issue;
  logic [BYTE_W-1:0]  bus_data;
  logic               pin_value;
  logic [BYTE_W-1:0]  input_byte;

  modport source (output valid, output issue, output bus_data, output pin_value,
                  output input_byte, input ready);
  modport sink (input valid, input issue, input bus_data, input pin_value,
                input input_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/io_expander_poll_controller.sv]
// Top level of the I/O expander poll controller.
// Takes one command item per clock cycle on in_i while out_o is not stalled, and returns
// exactly one result per item on out_o, in order, through one input register and one
// result register. Decode and state update are combinational between the two, so the
// next item is taken in the very next cycle as long as the result register can drain;
// out_o back-pressure stalls the input register and then in_i. Write tick_period_ms
// through cfg_we_i/cfg_wdata_i only while no item is in flight.
`default_nettype none

module io_expander_poll_controller #(
  parameter int READ_PERIOD_MS = 50,
  parameter int WRAP_MS        = 1000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  iepc_in_if.sink                       in_i,
  iepc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [iepc_pkg::PERIOD_W-1:0] cfg_wdata_i
);
  import iepc_pkg::*;

  logic [PERIOD_W-1:0] tick_period_q, tick_period_d;
  iepc_stage_t         stage;
  iepc_result_t        result;
  logic                can_load;
  logic                fire;

  assign tick_period_d = cfg_we_i ? cfg_wdata_i : tick_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= PERIOD_RESET;
    end else begin
      tick_period_q <= tick_period_d;
    end
  end

  assign fire = stage.valid && can_load;

  iepc_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .advance_i(can_load),
    .stage_o  (stage)
  );

  iepc_core #(
    .READ_PERIOD_MS(READ_PERIOD_MS),
    .WRAP_MS       (WRAP_MS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (stage.item),
    .tick_period_i(tick_period_q),
    .result_o     (result)
  );

  iepc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .result_i  (result),
    .can_load_o(can_load),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

[rtl/core/iepc_period_chk.sv]
// Divisibility test of the elapsed counter by the read period.
`default_nettype none

module iepc_period_chk #(
  parameter int READ_PERIOD_MS = 50
) (
  input  logic [iepc_pkg::ELAPSED_W-1:0] elapsed_i,
  output logic                           hit_o
);
  import iepc_pkg::*;

  localparam int RecipShift = ELAPSED_W + 11;
  localparam longint unsigned RecipL =
    ((64'd1 << RecipShift) + 64'(READ_PERIOD_MS) - 64'd1) / 64'(READ_PERIOD_MS);
  localparam int RecipW = $clog2(RecipL + 1);
  localparam int PeriodW = $clog2(READ_PERIOD_MS + 1);
  localparam int ProdW = ELAPSED_W + RecipW;
  localparam int BackW = ELAPSED_W + PeriodW;
  localparam logic [RecipW-1:0]  Recip  = RecipW'(RecipL);
  localparam logic [PeriodW-1:0] Period = PeriodW'(READ_PERIOD_MS);

  logic [ProdW-1:0]     prod;
  logic [ELAPSED_W-1:0] quot;
  logic [BackW-1:0]     back;

  assign prod  = ProdW'(elapsed_i) * ProdW'(Recip);
  assign quot  = ELAPSED_W'(prod >> RecipShift);
  assign back  = BackW'(quot) * BackW'(Period);
  assign hit_o = (back == BackW'(elapsed_i));

endmodule

`default_nettype wire

[rtl/core/iepc_in_reg.sv]
// Input register stage for command items.
`default_nettype none

module iepc_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iepc_in_if.sink               in_i,
  input  logic                  advance_i,
  output iepc_pkg::iepc_stage_t stage_o
);
  import iepc_pkg::*;

  logic       valid_q, valid_d;
  iepc_item_t item_q;
  logic       take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{kind: in_i.kind, data: in_i.data, pin: in_i.pin,
                  pin_level: in_i.pin_level, read_data: in_i.read_data};
    end
  end

  assign stage_o = '{valid: valid_q, item: item_q};

endmodule

`default_nettype wire

[rtl/core/iepc_out_reg.sv]
// Result register feeding the output channel.
`default_nettype none

module iepc_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  iepc_pkg::iepc_result_t result_i,
  output logic                   can_load_o,
  iepc_out_if.source             out_o
);
  import iepc_pkg::*;

  logic         valid_q, valid_d;
  iepc_result_t result_q;

  assign can_load_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.issue      = result_q.issue;
  assign out_o.bus_data   = result_q.bus_data;
  assign out_o.pin_value  = result_q.pin_value;
  assign out_o.input_byte = result_q.input_byte;

endmodule

`default_nettype wire

[rtl/core/iepc_core.sv]
// Controller state and per-item command decode.
`default_nettype none

module iepc_core #(
  parameter int READ_PERIOD_MS = 50,
  parameter int WRAP_MS        = 1000
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  iepc_pkg::iepc_item_t                 item_i,
  input  logic [iepc_pkg::PERIOD_W-1:0]        tick_period_i,
  output iepc_pkg::iepc_result_t               result_o
);
  import iepc_pkg::*;

  localparam int SumW = ELAPSED_W + 1;

  logic [BYTE_W-1:0]    shadow_q, shadow_d;
  logic [BYTE_W-1:0]    latched_q, latched_d;
  logic                 wr_pend_q, wr_pend_d;
  logic                 wr_busy_q, wr_busy_d;
  logic                 rd_pend_q, rd_pend_d;
  logic                 rd_busy_q, rd_busy_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [SumW-1:0]      sum;
  logic                 period_hit;
  logic                 pin_ok;
  logic [BYTE_W-1:0]    pin_mask;
  iepc_result_t         result_d;

  iepc_period_chk #(
    .READ_PERIOD_MS(READ_PERIOD_MS)
  ) u_period_chk (
    .elapsed_i(elapsed_q),
    .hit_o    (period_hit)
  );

  assign sum      = SumW'(elapsed_q) + SumW'(tick_period_i);
  assign pin_ok   = (item_i.pin <= PIN_MAX);
  assign pin_mask = BYTE_W'(1) << item_i.pin[2:0];

  always_comb begin
    shadow_d           = shadow_q;
    latched_d          = latched_q;
    wr_pend_d          = wr_pend_q;
    wr_busy_d          = wr_busy_q;
    rd_pend_d          = rd_pend_q;
    rd_busy_d          = rd_busy_q;
    elapsed_d          = elapsed_q;
    result_d.issue     = ISSUE_NONE;
    result_d.bus_data  = '0;
    result_d.pin_value = 1'b0;
    case (item_i.kind)
      KIND_TICK: begin
        if (wr_pend_q) begin
          wr_pend_d         = 1'b0;
          wr_busy_d         = 1'b1;
          result_d.issue    = ISSUE_WRITE;
          result_d.bus_data = shadow_q;
        end else if (rd_pend_q) begin
          rd_pend_d      = 1'b0;
          rd_busy_d      = 1'b1;
          result_d.issue = ISSUE_READ;
        end else begin
          if (period_hit) begin
            rd_busy_d      = 1'b1;
            result_d.issue = ISSUE_READ;
          end
          elapsed_d = (sum >= SumW'(WRAP_MS)) ? '0 : sum[ELAPSED_W-1:0];
        end
      end
      KIND_WRITE_BYTE: begin
        shadow_d  = item_i.data;
        wr_pend_d = 1'b1;
      end
      KIND_SET_PIN: begin
        if (pin_ok) begin
          shadow_d  = item_i.pin_level ? (shadow_q | pin_mask) : (shadow_q & ~pin_mask);
          wr_pend_d = 1'b1;
        end
      end
      KIND_REQ_READ: begin
        rd_pend_d = 1'b1;
      end
      KIND_BUS_DONE: begin
        if (wr_busy_q) begin
          wr_busy_d = 1'b0;
        end else if (rd_busy_q) begin
          rd_busy_d = 1'b0;
          latched_d = item_i.read_data;
        end
      end
      KIND_GET_PIN: begin
        if (pin_ok) begin
          result_d.pin_value = latched_q[item_i.pin[2:0]];
        end
      end
      default: begin
      end
    endcase
    result_d.input_byte = latched_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q  <= BYTE_RESET;
      latched_q <= BYTE_RESET;
      wr_pend_q <= 1'b0;
      wr_busy_q <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_busy_q <= 1'b0;
      elapsed_q <= '0;
    end else if (fire_i) begin
      shadow_q  <= shadow_d;
      latched_q <= latched_d;
      wr_pend_q <= wr_pend_d;
      wr_busy_q <= wr_busy_d;
      rd_pend_q <= rd_pend_d;
      rd_busy_q <= rd_busy_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign result_o = result_d;

`include "io_expander_poll_controller_assert.svh"

  `IEPC_ASSERT_IMPL(a_elapsed_below_wrap, 1'b1, elapsed_q < ELAPSED_W'(WRAP_MS), "elapsed counter reached the wrap limit")
  `IEPC_ASSERT_NEXT(a_write_issue_sets_busy, fire_i && result_d.issue == ISSUE_WRITE, wr_busy_q && !wr_pend_q, "write transfer did not mark the bus busy")
  `IEPC_ASSERT_NEXT(a_read_issue_sets_busy, fire_i && result_d.issue == ISSUE_READ, rd_busy_q, "read transfer did not mark the read busy")
  `IEPC_ASSERT_NEXT(a_idle_holds_state, !fire_i, $stable(shadow_q) && $stable(latched_q) && $stable(elapsed_q), "state changed without an item")

endmodule

`default_nettype wire

[tb/io_expander_poll_controller_test.sv]
// Self-checking testbench for the I/O expander poll controller: directed and random commands.
module io_expander_poll_controller_test;
  import iepc_pkg::*;

  localparam int READ_PERIOD_MS = 50;
  localparam int WRAP_MS        = 1000;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASE_ITEMS    = 110;
  localparam int ItemW          = $bits(iepc_item_t);

  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_STALLS} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [PERIOD_W-1:0] cfg_wdata_i;

  iepc_in_if  cmd_if ();
  iepc_out_if res_if ();

  io_expander_poll_controller #(
    .READ_PERIOD_MS(READ_PERIOD_MS),
    .WRAP_MS       (WRAP_MS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the controller state
  logic [PERIOD_W-1:0]  tick_period;
  logic [BYTE_W-1:0]    shadow_byte;
  logic [BYTE_W-1:0]    latched_byte;
  logic                 write_pending;
  logic                 write_busy;
  logic                 read_pending;
  logic                 read_busy;
  logic [ELAPSED_W-1:0] elapsed_ms;

  iepc_result_t due_responses[$];

  int unsigned mismatch_count    = 0;
  int unsigned commands_sent     = 0;
  int unsigned responses_checked = 0;
  int unsigned writes_issued     = 0;
  int unsigned reads_issued      = 0;
  int unsigned periods_used      = 0;
  int unsigned burst_left        = 0;
  int unsigned idle_cycles       = 0;

  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  task automatic reset_poll_state();
    tick_period   = PERIOD_RESET;
    shadow_byte   = BYTE_RESET;
    latched_byte  = BYTE_RESET;
    write_pending = 1'b0;
    write_busy    = 1'b0;
    read_pending  = 1'b0;
    read_busy     = 1'b0;
    elapsed_ms    = '0;
  endtask

  function automatic iepc_result_t poll_step(input iepc_item_t it);
    iepc_result_t r;
    int           sum;
    r.issue     = ISSUE_NONE;
    r.bus_data  = '0;
    r.pin_value = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (write_pending) begin
          write_pending = 1'b0;
          write_busy    = 1'b1;
          r.issue       = ISSUE_WRITE;
          r.bus_data    = shadow_byte;
        end else if (read_pending) begin
          read_pending = 1'b0;
          read_busy    = 1'b1;
          r.issue      = ISSUE_READ;
        end else begin
          if ((int'(elapsed_ms) % READ_PERIOD_MS) == 0) begin
            read_busy = 1'b1;
            r.issue   = ISSUE_READ;
          end
          sum = int'(elapsed_ms) + int'(tick_period);
          elapsed_ms = (sum >= WRAP_MS) ? '0 : ELAPSED_W'(sum);
        end
      end
      KIND_WRITE_BYTE: begin
        shadow_byte   = it.data;
        write_pending = 1'b1;
      end
      KIND_SET_PIN: begin
        if (it.pin <= PIN_MAX) begin
          shadow_byte[it.pin[2:0]] = it.pin_level;
          write_pending = 1'b1;
        end
      end
      KIND_REQ_READ: read_pending = 1'b1;
      KIND_BUS_DONE: begin
        if (write_busy) begin
          write_busy = 1'b0;
        end else if (read_busy) begin
          read_busy    = 1'b0;
          latched_byte = it.read_data;
        end
      end
      KIND_GET_PIN: begin
        if (it.pin <= PIN_MAX) r.pin_value = latched_byte[it.pin[2:0]];
      end
      default: ;
    endcase
    r.input_byte = latched_byte;
    return r;
  endfunction

  function automatic iepc_item_t make_item(input logic [KIND_W-1:0] k,
                                           input logic [BYTE_W-1:0] d,
                                           input logic [PIN_W-1:0]  p,
                                           input logic              lvl,
                                           input logic [BYTE_W-1:0] rd);
    iepc_item_t it;
    it.kind      = k;
    it.data      = d;
    it.pin       = p;
    it.pin_level = lvl;
    it.read_data = rd;
    return it;
  endfunction

  function automatic iepc_item_t random_item(input logic [KIND_W-1:0] k);
    iepc_item_t it;
    it      = ItemW'($urandom);
    it.kind = k;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_command(input iepc_item_t it);
    cmd_if.valid     <= 1'b1;
    cmd_if.kind      <= it.kind;
    cmd_if.data      <= it.data;
    cmd_if.pin       <= it.pin;
    cmd_if.pin_level <= it.pin_level;
    cmd_if.read_data <= it.read_data;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    due_responses.push_back(poll_step(it));
    commands_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic drain_responses();
    cmd_if.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tick_period(input logic [PERIOD_W-1:0] value);
    drain_responses();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tick_period = value;
    periods_used++;
  endtask

  task automatic test_startup_read();
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_BUS_DONE, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_GET_PIN, 8'hFF, 4'd0, 1'b1, 8'hFF));
  endtask

  task automatic test_write_paths();
    send_command(make_item(KIND_WRITE_BYTE, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_BUS_DONE, 8'h00, 4'd0, 1'b0, 8'hFF));
    send_command(make_item(KIND_SET_PIN, 8'h00, 4'd7, 1'b0, 8'h00));
    send_command(make_item(KIND_SET_PIN, 8'hFF, 4'd0, 1'b1, 8'hFF));
    send_command(make_item(KIND_SET_PIN, 8'h00, 4'd15, 1'b1, 8'h00));
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_BUS_DONE, 8'h00, 4'd0, 1'b0, 8'h00));
  endtask

  task automatic test_read_paths();
    send_command(make_item(KIND_REQ_READ, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_BUS_DONE, 8'h00, 4'd0, 1'b0, 8'hA5));
    send_command(make_item(KIND_GET_PIN, 8'h00, 4'd7, 1'b0, 8'h00));
    send_command(make_item(KIND_GET_PIN, 8'h00, 4'd15, 1'b0, 8'h00));
    send_command(make_item(KIND_BUS_DONE, 8'h00, 4'd0, 1'b0, 8'h5A));
    send_command(make_item(KIND_WRITE_BYTE, 8'h3C, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_REQ_READ, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
  endtask

  task automatic test_unused_kinds();
    send_command(make_item(KIND_SPARE_6, 8'hFF, 4'd15, 1'b1, 8'hFF));
    send_command(make_item(KIND_SPARE_7, 8'h00, 4'd0, 1'b0, 8'h00));
  endtask

  task automatic test_tick_period_zero();
    set_tick_period('0);
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
    send_command(make_item(KIND_TICK, 8'h00, 4'd0, 1'b0, 8'h00));
  endtask

  task automatic run_poll_exchange();
    iepc_item_t it;
    if ($urandom_range(0, 9) < 3) begin
      send_command(random_item(KIND_W'($urandom_range(0, 7))));
      return;
    end
    case ($urandom_range(0, 3))
      0: send_command(random_item(KIND_WRITE_BYTE));
      1: begin
        it = random_item(KIND_SET_PIN);
        it.pin[3] = ($urandom_range(0, 5) == 0);
        send_command(it);
      end
      2: send_command(random_item(KIND_REQ_READ));
      default: ;
    endcase
    repeat ($urandom_range(1, 3)) send_command(random_item(KIND_TICK));
    send_command(random_item(KIND_BUS_DONE));
    if ($urandom_range(0, 2) == 0) send_command(random_item(KIND_BUS_DONE));
    it = random_item(KIND_GET_PIN);
    it.pin[3] = ($urandom_range(0, 5) == 0);
    send_command(it);
  endtask

  task automatic test_random_traffic();
    int unsigned settings[10];
    int unsigned phase_end;
    settings = '{1, 1000, 0, 50, 1023, 7, 999, 0, 0, 0};
    for (int i = 7; i < 10; i++) settings[i] = $urandom_range(1, 1000);
    foreach (settings[i]) begin
      set_tick_period(PERIOD_W'(settings[i]));
      phase_end = commands_sent + PHASE_ITEMS;
      while (commands_sent < phase_end) run_poll_exchange();
    end
  endtask

  // Receiver back-pressure: open, choppy, or long stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   res_if.ready <= 1'b1;
        RX_CHOPPY: res_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 11);
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    iepc_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_responses.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = due_responses.pop_front();
        responses_checked++;
        if (want.issue == ISSUE_WRITE) writes_issued++;
        if (want.issue == ISSUE_READ) reads_issued++;
        if (res_if.issue !== want.issue)
          report_mismatch($sformatf("issue got %0d want %0d", res_if.issue, want.issue));
        if (res_if.bus_data !== want.bus_data)
          report_mismatch($sformatf("bus_data got %h want %h", res_if.bus_data,
                                    want.bus_data));
        if (res_if.pin_value !== want.pin_value)
          report_mismatch($sformatf("pin_value got %b want %b", res_if.pin_value,
                                    want.pin_value));
        if (res_if.input_byte !== want.input_byte)
          report_mismatch($sformatf("input_byte got %h want %h", res_if.input_byte,
                                    want.input_byte));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("no transfer for %0d cycles", IDLE_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    cmd_if.valid     <= 1'b0;
    cmd_if.kind      <= '0;
    cmd_if.data      <= '0;
    cmd_if.pin       <= '0;
    cmd_if.pin_level <= 1'b0;
    cmd_if.read_data <= '0;
    reset_poll_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_startup_read();
    test_write_paths();
    test_read_paths();
    test_unused_kinds();
    test_tick_period_zero();
    test_random_traffic();

    drain_responses();
    repeat (8) @(posedge clk_i);
    $display("covered %0d commands over %0d tick period settings (0 to 1023)",
             commands_sent, periods_used);
    $display("checked %0d results: %0d bus writes, %0d bus reads issued",
             responses_checked, writes_issued, reads_issued);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
